// ===== rtl/assert_macros.svh =====
// assertion helpers used by indexed_list_store_core
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/ils_pkg.sv =====
// types, codes and helpers for the indexed list store
// no dependencies
`default_nettype none

package ils_pkg;

    // position fields are wide enough for lists of up to 127 entries
    localparam int LIST_POS_BITS = 7;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_POP    = 3'd4,
        OP_CLEAR  = 3'd5
    } t_list_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_list_status;

    typedef struct packed {
        t_list_op           operation;
        logic signed [7:0]  index;
        logic [31:0]        value;
    } t_list_req;

    typedef struct packed {
        logic [31:0]  read_value;
        t_list_status status;
        logic [4:0]   count;
    } t_list_rsp;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd                cmd;
        logic [LIST_POS_BITS-1:0] pos;
        logic [LIST_POS_BITS-1:0] lim;
    } t_cell_ctl;

    // length as reported in a result: low five bits
    function automatic logic [4:0] to_count(input logic [7:0] len);
        return len[4:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ils_cell.sv =====
// one entry of the list chain: holds a word, loads from the broadcast value
// or from a neighbor depending on its own position; uses ils_pkg
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int IDX       = 0
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic [WORD_BITS-1:0] i_left,
    input  wire logic [WORD_BITS-1:0] i_right,
    output logic      [WORD_BITS-1:0] o_word
);

    localparam logic [LIST_POS_BITS:0] SELF = (LIST_POS_BITS + 1)'(IDX);
    localparam logic [LIST_POS_BITS:0] NEXT = (LIST_POS_BITS + 1)'(IDX + 1);

    logic [WORD_BITS-1:0]   r_word;
    logic [WORD_BITS-1:0]   n_word;
    logic [LIST_POS_BITS:0] pos;
    logic [LIST_POS_BITS:0] lim;

    always_comb begin
        pos    = {1'b0, i_ctl.pos};
        lim    = {1'b0, i_ctl.lim};
        n_word = r_word;
        case (i_ctl.cmd)
            CELL_WRITE: begin
                if (SELF == pos) n_word = i_value;
            end
            CELL_INSERT: begin
                // entries from pos up to the old end move one place up
                if (SELF == pos) begin
                    n_word = i_value;
                end else if (SELF > pos && SELF <= lim) begin
                    n_word = i_left;
                end
            end
            CELL_REMOVE: begin
                // close the gap left at pos
                if (SELF >= pos && NEXT < lim) n_word = i_right;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store_core.sv =====
// Bounded ordered list of DEPTH words with signed, python-style indexing
// (get, set, append, insert, pop, clear; negative index counts from the end).
// Each entry lives in a cell of a chain; one command is broadcast to all cells,
// so shifts for insert and pop happen in all cells together. A request is taken
// every cycle while the output register is free or being drained, and its
// result is in the output register in the cycle after the transfer. Entries
// have no reset: the length is cleared at reset and only entries below it are
// ever read. Status reports out-of-range for get, set and pop, and full for
// append or insert on a full list, which then leave the list unchanged.
`default_nettype none
`include "assert_macros.svh"

module indexed_list_store_core
    import ils_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_list_req i_in_req,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_list_rsp      o_out_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = ((CW > 8) ? CW : 8) + 2;

    logic [CW-1:0]          r_fill;
    logic [CW-1:0]          n_fill;
    logic                   r_out_valid;
    t_list_rsp              r_rsp;
    t_list_rsp              n_rsp;
    t_cell_ctl              ctl;
    logic                   in_fire;
    logic                   full;
    logic                   in_range;
    logic signed [PW-1:0]   idx_s;
    logic signed [PW-1:0]   fill_s;
    logic signed [PW-1:0]   rel;
    logic signed [PW-1:0]   ins_pos;
    logic [63:0]            val64;
    logic [63:0]            rd64;
    logic [WORD_BITS-1:0]   cell_val;
    logic [WORD_BITS-1:0]   words   [DEPTH];
    logic [WORD_BITS-1:0]   left_w  [DEPTH];
    logic [WORD_BITS-1:0]   right_w [DEPTH];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_fire    = i_in_valid & ~o_in_stall;

    // index resolution against the current length
    always_comb begin
        idx_s    = PW'(i_in_req.index);
        fill_s   = $signed({{(PW - CW){1'b0}}, r_fill});
        rel      = (idx_s < 0) ? fill_s + idx_s : idx_s;
        in_range = (rel >= 0) && (rel < fill_s);
        if (rel < 0) begin
            ins_pos = '0;
        end else if (rel > fill_s) begin
            ins_pos = fill_s;
        end else begin
            ins_pos = rel;
        end
        full = (r_fill == CW'(DEPTH));
    end

    always_comb begin
        val64    = 64'(i_in_req.value);
        cell_val = val64[WORD_BITS-1:0];
        rd64     = '0;
        rd64[WORD_BITS-1:0] = words[rel[AW-1:0]];
    end

    always_comb begin
        ctl.cmd          = CELL_HOLD;
        ctl.pos          = '0;
        ctl.lim          = LIST_POS_BITS'(r_fill);
        n_fill           = r_fill;
        n_rsp.read_value = '0;
        n_rsp.status     = ST_OK;
        case (i_in_req.operation)
            OP_GET: begin
                if (in_range) n_rsp.read_value = rd64[31:0];
                else          n_rsp.status     = ST_RANGE;
            end
            OP_SET: begin
                if (in_range) begin
                    ctl.cmd = CELL_WRITE;
                    ctl.pos = rel[LIST_POS_BITS-1:0];
                end else begin
                    n_rsp.status = ST_RANGE;
                end
            end
            OP_APPEND: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    ctl.cmd = CELL_INSERT;
                    ctl.pos = LIST_POS_BITS'(r_fill);
                    n_fill  = r_fill + CW'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    ctl.cmd = CELL_INSERT;
                    ctl.pos = ins_pos[LIST_POS_BITS-1:0];
                    n_fill  = r_fill + CW'(1);
                end
            end
            OP_POP: begin
                if (in_range) begin
                    n_rsp.read_value = rd64[31:0];
                    ctl.cmd          = CELL_REMOVE;
                    ctl.pos          = rel[LIST_POS_BITS-1:0];
                    n_fill           = r_fill - CW'(1);
                end else begin
                    n_rsp.status = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
        n_rsp.count = to_count(8'(n_fill));
        if (!in_fire) ctl.cmd = CELL_HOLD;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_w[g] = '0;
        end else begin : g_left
            assign left_w[g] = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w[g] = '0;
        end else begin : g_right
            assign right_w[g] = words[g+1];
        end

        ils_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (cell_val),
            .i_left  (left_w[g]),
            .i_right (right_w[g]),
            .o_word  (words[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_rsp <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    `ASSERT_ALWAYS(a_fill_bound, r_fill <= CW'(DEPTH), "list length above capacity")
    `ASSERT_NEXT(a_count_match, in_fire, r_rsp.count == to_count(8'(r_fill)),
                 "reported count differs from list length")
    `ASSERT_NEXT(a_full_no_change, in_fire && n_rsp.status == ST_FULL, $stable(r_fill),
                 "full list changed length")

endmodule

`default_nettype wire
